/* rtl/gmbp_pkg.sv */
// Shared types and constants for the grid maze backtracking path solver.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package gmbp_pkg;

  // Side of the square grid; the coordinate fields are three bits wide.
  localparam int GRID_DIM  = 8;
  localparam int NUM_CELLS = 64;
  localparam int CELL_W    = 6;
  localparam int COORD_W   = 3;
  localparam int COUNT_W   = 7;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Neighbor order of the search; DIR_DONE means every branch was tried.
  typedef enum logic [2:0] {
    DIR_UP,
    DIR_LEFT,
    DIR_DOWN,
    DIR_RIGHT,
    DIR_DONE
  } dir_t;

  typedef struct packed {
    cell_t pos;
    dir_t  dir;
  } stk_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_POP,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_EMIT_GOAL,
    S_FAIL
  } state_t;

endpackage

/* rtl/gmbp_req_if.sv */
// Request channel of the maze solver: a start cell and a goal cell.
// Depends on gmbp_pkg for the coordinate type.
`timescale 1ns / 1ps

interface gmbp_req_if import gmbp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_row;
  coord_t start_col;
  coord_t goal_row;
  coord_t goal_col;

  modport source (output valid, start_row, start_col, goal_row, goal_col, input ready);
  modport sink   (input valid, start_row, start_col, goal_row, goal_col, output ready);
endinterface

/* rtl/gmbp_path_if.sv */
// Result channel of the maze solver: one path cell per word, with a last flag.
// Depends on gmbp_pkg for the coordinate type.
`timescale 1ns / 1ps

interface gmbp_path_if import gmbp_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   found;
  coord_t cell_row;
  coord_t cell_col;
  logic   last;

  modport source (output valid, found, cell_row, cell_col, last, input ready);
  modport sink   (input valid, found, cell_row, cell_col, last, output ready);
endinterface

/* rtl/grid_maze_backtracking_path.sv */
// Top level of the grid maze backtracking path solver.
// Depends on gmbp_pkg and on the gmbp_req_if and gmbp_path_if interfaces.
`timescale 1ns / 1ps

// The block takes one request word (start and goal cell on an 8x8 grid) and
// runs a depth-first backtracking search over the walls held in cfg_wdata's
// register, trying neighbors in the order up, left, down, right. It then
// sends the path from start to goal, one word per cell with last set on the
// goal, or a single word with found low when no path exists. A goal cell
// counts as reached even when it is a wall. A new request is taken only when
// the previous one has sent its last word. The request is accepted, then
// each neighbor is tried in turn; a backtrack first sees that every branch
// was tried, then waits for the stack memory's registered read. Each path
// cell before the goal is read from the stack memory and then sent, and the
// goal or failure word comes last, each stretched by any output stall. The
// wall register may be written only while no request is in progress.
module grid_maze_backtracking_path import gmbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [NUM_CELLS-1:0] cfg_wdata,
  gmbp_req_if.sink             in_req,
  gmbp_path_if.source          out_path
);

  // Control and search state.
  state_t               state_r,     state_nxt;
  count_t               top_r,       top_nxt;      // number of cells on the path
  cell_t                top_cell_r,  top_cell_nxt; // top of stack lives in flops
  dir_t                 top_dir_r,   top_dir_nxt;
  logic [NUM_CELLS-1:0] marks_r,     marks_nxt;
  count_t               path_len_r,  path_len_nxt;
  count_t               emit_k_r,    emit_k_nxt;
  coord_t               goal_row_r,  goal_row_nxt;
  coord_t               goal_col_r,  goal_col_nxt;
  logic [NUM_CELLS-1:0] wall_r;

  // Stack memory below the top entry: one write and one read port.
  stk_entry_t           stack_mem [NUM_CELLS];
  stk_entry_t           rd_data_r;
  logic                 mem_we;
  cell_t                mem_wr_addr;
  stk_entry_t           mem_wdata;
  logic                 mem_re;
  cell_t                mem_rd_addr;

  // Shared neighbor unit: one signed step on a coordinate and its checks.
  logic [COORD_W:0]     nb_row;
  logic [COORD_W:0]     nb_col;
  logic                 nb_inside;
  logic                 nb_is_goal;
  cell_t                nb_cell;
  logic                 nb_free;
  count_t               top_m1;
  count_t               top_m2;
  logic                 start_inside;
  cell_t                start_cell;

  always_comb begin
    nb_row = {1'b0, top_cell_r[CELL_W-1:COORD_W]};
    nb_col = {1'b0, top_cell_r[COORD_W-1:0]};
    case (top_dir_r)
      DIR_UP:    nb_row = nb_row - 4'd1;
      DIR_LEFT:  nb_col = nb_col - 4'd1;
      DIR_DOWN:  nb_row = nb_row + 4'd1;
      DIR_RIGHT: nb_col = nb_col + 4'd1;
      default: begin
      end
    endcase
  end

  // A step below zero wraps to all ones, so bit 3 flags leaving the grid on
  // either side.
  assign nb_inside  = !nb_row[COORD_W] && !nb_col[COORD_W] &&
                      (nb_row < (COORD_W+1)'(GRID_DIM)) &&
                      (nb_col < (COORD_W+1)'(GRID_DIM));
  assign nb_is_goal = (nb_row == {1'b0, goal_row_r}) && (nb_col == {1'b0, goal_col_r});
  assign nb_cell    = {nb_row[COORD_W-1:0], nb_col[COORD_W-1:0]};
  assign nb_free    = nb_inside && !marks_r[nb_cell] && !wall_r[nb_cell];

  assign top_m1 = top_r - count_t'(1);
  assign top_m2 = top_r - count_t'(2);

  assign start_cell   = {in_req.start_row, in_req.start_col};
  assign start_inside = ({1'b0, in_req.start_row} < (COORD_W+1)'(GRID_DIM)) &&
                        ({1'b0, in_req.start_col} < (COORD_W+1)'(GRID_DIM));

  assign in_req.ready = (state_r == S_IDLE);

  // Sequencer: next state, stack control and result word.
  always_comb begin
    state_nxt    = state_r;
    top_nxt      = top_r;
    top_cell_nxt = top_cell_r;
    top_dir_nxt  = top_dir_r;
    marks_nxt    = marks_r;
    path_len_nxt = path_len_r;
    emit_k_nxt   = emit_k_r;
    goal_row_nxt = goal_row_r;
    goal_col_nxt = goal_col_r;
    mem_we       = 1'b0;
    mem_wr_addr  = top_m1[CELL_W-1:0];
    mem_wdata    = '{pos: top_cell_r, dir: dir_t'(top_dir_r + 3'd1)};
    mem_re       = 1'b0;
    mem_rd_addr  = top_m2[CELL_W-1:0];

    out_path.valid    = 1'b0;
    out_path.found    = 1'b1;
    out_path.cell_row = rd_data_r.pos[CELL_W-1:COORD_W];
    out_path.cell_col = rd_data_r.pos[COORD_W-1:0];
    out_path.last     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          goal_row_nxt = in_req.goal_row;
          goal_col_nxt = in_req.goal_col;
          marks_nxt    = '0;
          path_len_nxt = '0;
          emit_k_nxt   = '0;
          top_nxt      = '0;
          if ((in_req.start_row == in_req.goal_row) &&
              (in_req.start_col == in_req.goal_col)) begin
            state_nxt = S_EMIT_GOAL;
          end else if (start_inside && !wall_r[start_cell]) begin
            marks_nxt[start_cell] = 1'b1;
            top_cell_nxt = start_cell;
            top_dir_nxt  = DIR_UP;
            top_nxt      = count_t'(1);
            state_nxt    = S_STEP;
          end else begin
            state_nxt = S_FAIL;
          end
        end
      end

      S_STEP: begin
        if (top_dir_r == DIR_DONE) begin
          // Every branch failed: take the cell off the path and pop.
          marks_nxt[top_cell_r] = 1'b0;
          top_nxt = top_m1;
          if (top_r == count_t'(1)) begin
            state_nxt = S_FAIL;
          end else begin
            mem_re    = 1'b1;
            state_nxt = S_POP;
          end
        end else begin
          top_dir_nxt = dir_t'(top_dir_r + 3'd1);
          if (nb_is_goal) begin
            // Spill the top cell so the whole path sits in memory.
            mem_we       = 1'b1;
            path_len_nxt = top_r;
            emit_k_nxt   = '0;
            state_nxt    = S_EMIT_RD;
          end else if (nb_free) begin
            mem_we             = 1'b1;
            marks_nxt[nb_cell] = 1'b1;
            top_cell_nxt       = nb_cell;
            top_dir_nxt        = DIR_UP;
            top_nxt            = top_r + count_t'(1);
          end
        end
      end

      S_POP: begin
        top_cell_nxt = rd_data_r.pos;
        top_dir_nxt  = rd_data_r.dir;
        state_nxt    = S_STEP;
      end

      S_EMIT_RD: begin
        mem_re      = 1'b1;
        mem_rd_addr = emit_k_r[CELL_W-1:0];
        state_nxt   = S_EMIT_OUT;
      end

      S_EMIT_OUT: begin
        out_path.valid = 1'b1;
        if (out_path.ready) begin
          emit_k_nxt = emit_k_r + count_t'(1);
          if (emit_k_nxt == path_len_r) begin
            state_nxt = S_EMIT_GOAL;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end

      S_EMIT_GOAL: begin
        out_path.valid    = 1'b1;
        out_path.cell_row = goal_row_r;
        out_path.cell_col = goal_col_r;
        out_path.last     = 1'b1;
        if (out_path.ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_FAIL: begin
        out_path.valid    = 1'b1;
        out_path.found    = 1'b0;
        out_path.cell_row = '0;
        out_path.cell_col = '0;
        out_path.last     = 1'b1;
        if (out_path.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r      <= '0;
      marks_r    <= '0;
      wall_r     <= '0;
      path_len_r <= '0;
      emit_k_r   <= '0;
    end else begin
      top_r      <= top_nxt;
      marks_r    <= marks_nxt;
      path_len_r <= path_len_nxt;
      emit_k_r   <= emit_k_nxt;
      if (cfg_we) begin
        wall_r <= cfg_wdata;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    top_cell_r <= top_cell_nxt;
    top_dir_r  <= top_dir_nxt;
    goal_row_r <= goal_row_nxt;
    goal_col_r <= goal_col_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wr_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[mem_rd_addr];
    end
  end

endmodule

/* test/tb_grid_maze_backtracking_path.sv */
// Self-checking testbench for the grid maze backtracking path solver.
// Depends on gmbp_pkg, the gmbp_req_if and gmbp_path_if interfaces and the solver top level.
`timescale 1ns / 1ps

module tb_grid_maze_backtracking_path;
  import gmbp_pkg::*;

  // One word of the path channel, in the order the fields are compared.
  typedef struct packed {
    logic   found;
    coord_t row;
    coord_t col;
    logic   last;
  } path_word_t;

  // Handshake pressure of one stretch of traffic.
  typedef enum int {
    FLOW_STEADY,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
  } flow_t;

  localparam int  CLK_HALF_NS   = 6;
  localparam int  RESET_CYCLES  = 12;
  // The search can visit every simple path of an open region, which explodes.
  // Requests whose search would take more steps than this are not sent; random ones are drawn again.
  localparam int  SEARCH_BUDGET = 1500;
  localparam int  MAX_SEND_GAP  = 12;
  localparam int  MAX_STALL_RUN = 10;
  localparam int  TAIL_CYCLES   = 64;
  localparam int  MAX_REPORTS   = 100;
  localparam int  PHASES        = 16;
  localparam int  PHASE_ITEMS   = 25;
  // Limit for the whole run, given in clock periods and scaled to nanoseconds.
  localparam longint TIMEOUT_NS = 64'd5_000_000 * 2 * CLK_HALF_NS;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [NUM_CELLS-1:0] cfg_wdata;

  gmbp_req_if  req_bus ();
  gmbp_path_if path_bus ();

  grid_maze_backtracking_path u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_bus),
    .out_path  (path_bus)
  );

  // Wall map the solver currently holds, tracked on the testbench side.
  logic [NUM_CELLS-1:0] wall_map_shadow;

  // Path words still owed by the solver, oldest first.
  path_word_t pending_path_q[$];

  // Result of the most recent maze solve: the cells before the goal.
  cell_t trail_cells [NUM_CELLS];
  int    trail_len;
  bit    trail_found;

  int send_idle_pct;
  int recv_stall_pct;

  int error_count;
  int request_count;
  int words_checked;
  int paths_found;
  int searches_failed;
  int longest_path;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Hard stop in case the solver hangs or drops words.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_grid_maze_backtracking_path: errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  // A cell can be entered when it lies in the grid, is no wall and is not
  // already on the path being built.
  function automatic bit open_cell(input int r, input int c,
                                   input logic [NUM_CELLS-1:0] walls,
                                   input logic [NUM_CELLS-1:0] marks);
    if (r < 0 || c < 0 || r >= GRID_DIM || c >= GRID_DIM) begin
      return 1'b0;
    end
    return !walls[r * 8 + c] && !marks[r * 8 + c];
  endfunction

  // Depth-first search with backtracking, neighbors tried up, left, down,
  // right. Leaves the cells in front of the goal in trail_cells. Returns 0
  // when the search would need more than SEARCH_BUDGET steps.
  function automatic bit solve_maze(input logic [NUM_CELLS-1:0] walls,
                                    input coord_t sr, input coord_t sc,
                                    input coord_t gr, input coord_t gc);
    logic [NUM_CELLS-1:0] marks;
    cell_t stack_cell [NUM_CELLS];
    dir_t  stack_dir  [NUM_CELLS];
    int    depth;
    int    steps;
    int    r;
    int    c;
    int    nr;
    int    nc;
    int    t;
    trail_len   = 0;
    trail_found = 1'b0;
    if (sr == gr && sc == gc) begin
      trail_found = 1'b1;
      return 1'b1;
    end
    marks = '0;
    depth = 0;
    steps = 0;
    if (open_cell(int'(sr), int'(sc), walls, marks)) begin
      stack_cell[0] = {sr, sc};
      stack_dir[0]  = DIR_UP;
      marks[{sr, sc}] = 1'b1;
      depth = 1;
    end
    while (depth > 0) begin
      steps++;
      if (steps > SEARCH_BUDGET) begin
        return 1'b0;
      end
      t = depth - 1;
      r = int'(stack_cell[t][5:3]);
      c = int'(stack_cell[t][2:0]);
      if (stack_dir[t] == DIR_DONE) begin
        // Every branch of this cell failed: take it off the path again.
        marks[stack_cell[t]] = 1'b0;
        depth--;
        continue;
      end
      nr = r;
      nc = c;
      case (stack_dir[t])
        DIR_UP:   nr = r - 1;
        DIR_LEFT: nc = c - 1;
        DIR_DOWN: nr = r + 1;
        default:  nc = c + 1;
      endcase
      stack_dir[t] = dir_t'(stack_dir[t] + 1);
      // The goal is reached before any bounds, wall or mark test.
      if (nr == int'(gr) && nc == int'(gc)) begin
        for (int k = 0; k < depth; k++) begin
          trail_cells[k] = stack_cell[k];
        end
        trail_len   = depth;
        trail_found = 1'b1;
        return 1'b1;
      end
      if (open_cell(nr, nc, walls, marks)) begin
        stack_cell[depth] = cell_t'(nr * 8 + nc);
        stack_dir[depth]  = DIR_UP;
        marks[nr * 8 + nc] = 1'b1;
        depth++;
      end
    end
    return 1'b1;
  endfunction

  // Predicts the path words of one request and sends it. The request is not
  // sent, and sent comes back low, when its search runs past the budget.
  task automatic issue_request(input coord_t sr, input coord_t sc,
                               input coord_t gr, input coord_t gc,
                               output bit sent);
    int gap;
    sent = solve_maze(wall_map_shadow, sr, sc, gr, gc);
    if (!sent) begin
      return;
    end
    if (trail_found) begin
      for (int k = 0; k < trail_len; k++) begin
        pending_path_q.push_back('{1'b1, trail_cells[k][5:3], trail_cells[k][2:0], 1'b0});
      end
      pending_path_q.push_back('{1'b1, gr, gc, 1'b1});
      paths_found++;
      if (trail_len + 1 > longest_path) begin
        longest_path = trail_len + 1;
      end
    end else begin
      pending_path_q.push_back('{1'b0, coord_t'(0), coord_t'(0), 1'b1});
      searches_failed++;
    end
    request_count++;

    gap = 0;
    while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    @(negedge clk);
    while (gap > 0) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
      gap--;
    end
    req_bus.valid     <= 1'b1;
    req_bus.start_row <= sr;
    req_bus.start_col <= sc;
    req_bus.goal_row  <= gr;
    req_bus.goal_col  <= gc;
    do begin
      @(posedge clk);
    end while (!req_bus.ready);
  endtask

  // Drops valid and holds off until every owed word has arrived.
  task automatic drain_results();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_path_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // The wall map is only written while the solver is idle.
  task automatic load_walls(input logic [NUM_CELLS-1:0] walls);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= walls;
    @(negedge clk);
    cfg_we    <= 1'b0;
    wall_map_shadow = walls;
  endtask

  task automatic set_flow(input flow_t flow);
    case (flow)
      FLOW_STEADY: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      FLOW_SEND_GAPS: begin
        send_idle_pct  = 77;
        recv_stall_pct = 0;
      end
      FLOW_RECV_STALLS: begin
        send_idle_pct  = 0;
        recv_stall_pct = 77;
      end
      default: begin
        send_idle_pct  = 23;
        recv_stall_pct = 23;
      end
    endcase
  endtask

  // Reset value of the wall map: an empty grid. Corner to corner snakes down and
  // up every column but the last, giving a path of 57 words.
  task automatic test_open_grid();
    bit sent;
    issue_request(3'd0, 3'd0, 3'd7, 3'd7, sent);
    issue_request(3'd7, 3'd7, 3'd0, 3'd0, sent);
    issue_request(3'd3, 3'd5, 3'd3, 3'd5, sent);
  endtask

  // A small pocket in the top left corner forces dead ends and backtracking.
  // Walls sit at (0,0) (0,2) (1,0) (1,2) (2,0) (3,1) (3,2).
  task automatic test_pocket_walls();
    bit sent;
    load_walls(64'h0000_0000_0601_0505);
    // The upward branch dies, the search backs out and goes right.
    issue_request(3'd2, 3'd1, 3'd2, 3'd3, sent);
    // The goal is a wall, but it still counts as reached after a backtrack.
    issue_request(3'd1, 3'd1, 3'd1, 3'd0, sent);
    // A start on a wall fails outright, unless it is also the goal.
    issue_request(3'd0, 3'd0, 3'd5, 3'd5, sent);
    issue_request(3'd0, 3'd2, 3'd0, 3'd2, sent);
    // Closing (2,2) seals the pocket, so the far corner is out of reach.
    load_walls(64'h0000_0000_0605_0505);
    issue_request(3'd2, 3'd1, 3'd7, 3'd7, sent);
  endtask

  // Every cell a wall: only a start that equals its goal succeeds, even with
  // the goal right next to the start.
  task automatic test_full_walls();
    bit sent;
    load_walls('1);
    issue_request(3'd4, 3'd4, 3'd4, 3'd5, sent);
    issue_request(3'd7, 3'd0, 3'd7, 3'd0, sent);
    issue_request(3'd0, 3'd7, 3'd7, 3'd0, sent);
    issue_request(3'd3, 3'd3, 3'd2, 3'd3, sent);
  endtask

  // Random mazes of varied density, with the handshake pressure rotating
  // from phase to phase. Most starts are free cells so that searches go deep.
  task automatic test_random_mazes();
    logic [NUM_CELLS-1:0] walls;
    coord_t sr;
    coord_t sc;
    coord_t gr;
    coord_t gc;
    int     density;
    bit     sent;
    for (int phase = 0; phase < PHASES; phase++) begin
      density = 10 + 10 * (phase % 5);
      walls = '0;
      if (phase == 9) begin
        walls = '1;
      end else if (phase != 0) begin
        for (int b = 0; b < NUM_CELLS; b++) begin
          walls[b] = ($urandom_range(99) < density);
        end
      end
      load_walls(walls);
      set_flow(flow_t'(phase % 4));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Now and then the sender waits for the solver to empty out.
        if ($urandom_range(19) == 0) begin
          drain_results();
        end
        do begin
          {sr, sc} = cell_t'($urandom_range(NUM_CELLS - 1));
          if ($urandom_range(9) == 0) begin
            {gr, gc} = {sr, sc};
          end else begin
            if ($urandom_range(9) != 0) begin
              for (int k = 0; k < NUM_CELLS && walls[{sr, sc}]; k++) begin
                {sr, sc} = cell_t'($urandom_range(NUM_CELLS - 1));
              end
            end
            {gr, gc} = cell_t'($urandom_range(NUM_CELLS - 1));
          end
          issue_request(sr, sc, gr, gc, sent);
        end while (!sent);
      end
    end
  endtask

  // Receiver: ready drops at random, but never for more than a short run.
  initial begin
    int stall_run;
    stall_run      = 0;
    path_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_run < MAX_STALL_RUN && $urandom_range(99) < recv_stall_pct) begin
        path_bus.ready <= 1'b0;
        stall_run++;
      end else begin
        path_bus.ready <= 1'b1;
        stall_run = 0;
      end
    end
  end

  // Every accepted path word is compared with the oldest owed word.
  always @(posedge clk) begin
    path_word_t owed;
    if (rst_n && path_bus.valid && path_bus.ready) begin
      if (pending_path_q.size() == 0) begin
        report_mismatch("unexpected word, row", int'(path_bus.cell_row), -1);
      end else begin
        owed = pending_path_q.pop_front();
        words_checked++;
        if (path_bus.found !== owed.found) begin
          report_mismatch("found", int'(path_bus.found), int'(owed.found));
        end
        if (path_bus.cell_row !== owed.row) begin
          report_mismatch("cell_row", int'(path_bus.cell_row), int'(owed.row));
        end
        if (path_bus.cell_col !== owed.col) begin
          report_mismatch("cell_col", int'(path_bus.cell_col), int'(owed.col));
        end
        if (path_bus.last !== owed.last) begin
          report_mismatch("last", int'(path_bus.last), int'(owed.last));
        end
      end
    end
  end

  // Main sequence: reset, the directed cases, then the random mazes, and a
  // final drain with a quiet tail in which no stray word may appear.
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_bus.valid     = 1'b0;
    req_bus.start_row = '0;
    req_bus.start_col = '0;
    req_bus.goal_row  = '0;
    req_bus.goal_col  = '0;
    wall_map_shadow   = '0;
    error_count       = 0;
    request_count     = 0;
    words_checked     = 0;
    paths_found       = 0;
    searches_failed   = 0;
    longest_path      = 0;
    set_flow(FLOW_STEADY);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_open_grid();
    test_pocket_walls();
    test_full_walls();
    test_random_mazes();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_path_q.size() != 0) begin
      report_mismatch("words never sent", 0, pending_path_q.size());
    end

    $display("Solved %0d requests over empty, full and random wall maps: %0d paths found,",
             request_count, paths_found);
    $display("%0d searches failed, longest path %0d cells, %0d words checked.",
             searches_failed, longest_path, words_checked);
    if (error_count == 0) begin
      $display("tb_grid_maze_backtracking_path: clean");
    end else begin
      $display("tb_grid_maze_backtracking_path: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/gmbp_pkg.sv
rtl/gmbp_req_if.sv
rtl/gmbp_path_if.sv
rtl/grid_maze_backtracking_path.sv
test/tb_grid_maze_backtracking_path.sv
